### hdl/dset_pkg.sv
`timescale 1ns / 1ps

package dset_pkg;

  // Field types of the input and result channels.
  typedef logic signed [31:0] word_t;
  typedef logic [31:0]        mag_t;
  typedef logic [6:0]         dsum_t;
  typedef logic [3:0]         digit_t;

  // Division by ten as a multiply by the scaled reciprocal, exact for any 32-bit value.
  localparam logic [31:0] DivRecip = 32'hCCCC_CCCD;
  localparam int          DivShift = 35;

endpackage

### hdl/digit_sum_extremum_tracker.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_value, in_last
// out_      output     out_valid / out_ready  out_digit_sum, out_max_sum, out_max_number,
//                                             out_min_sum, out_min_number, out_final_res
//
// An item passes from its transfer through a load step, one step for each decimal digit of
// its magnitude (up to ten), one step to finish the digit loop and one update step. The
// digit loop runs on a single divide-by-ten unit, a 32 by 32 reciprocal multiply, which
// produces one digit per cycle. in_ready is high only while the unit is idle.
// The result register lets a new item enter while the previous result waits; the update
// cycle holds until that result is transferred. Reset is synchronous and active low and
// clears the running extremes of the sequence.
module digit_sum_extremum_tracker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dset_pkg::word_t in_value,
  input  logic           in_last,
  output logic           out_valid,
  input  logic           out_ready,
  output dset_pkg::dsum_t out_digit_sum,
  output dset_pkg::dsum_t out_max_sum,
  output dset_pkg::word_t out_max_number,
  output dset_pkg::dsum_t out_min_sum,
  output dset_pkg::word_t out_min_number,
  output logic           out_final_res
);
  import dset_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIGIT = 2'd1;
  localparam logic [1:0] ST_CMP   = 2'd2;

  logic [1:0]  state_r;
  mag_t        mag_r;
  dsum_t       sum_r;
  word_t       val_r;
  logic        last_r;

  logic        have_any_r;
  dsum_t       hi_sum_r;
  word_t       hi_num_r;
  dsum_t       lo_sum_r;
  word_t       lo_num_r;

  logic        out_valid_r;
  dsum_t       out_digit_sum_r;
  dsum_t       out_max_sum_r;
  word_t       out_max_number_r;
  dsum_t       out_min_sum_r;
  word_t       out_min_number_r;
  logic        out_final_res_r;

  logic        in_xfer;
  logic        out_free;
  mag_t        in_mag;
  logic [63:0] prod;
  mag_t        quot;
  mag_t        quot_x10;
  digit_t      digit;
  logic        take_hi;
  logic        take_lo;
  dsum_t       hi_sum_nxt;
  word_t       hi_num_nxt;
  dsum_t       lo_sum_nxt;
  word_t       lo_num_nxt;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Magnitude of the input; the most negative value wraps to 2^31 as an unsigned word.
  assign in_mag = in_value[31] ? (~mag_t'(in_value) + 32'd1) : mag_t'(in_value);

  // Shared divide-by-ten unit: quotient by reciprocal multiply, digit by subtraction.
  assign prod     = {32'd0, mag_r} * {32'd0, DivRecip};
  assign quot     = mag_t'(prod[63:DivShift]);
  assign quot_x10 = {quot[28:0], 3'b000} + {quot[30:0], 1'b0};
  assign digit    = digit_t'(mag_r - quot_x10);

  // Extreme update; the first item of a sequence takes both, ties keep the older number.
  assign take_hi    = !have_any_r || (sum_r > hi_sum_r);
  assign take_lo    = !have_any_r || (sum_r < lo_sum_r);
  assign hi_sum_nxt = take_hi ? sum_r : hi_sum_r;
  assign hi_num_nxt = take_hi ? val_r : hi_num_r;
  assign lo_sum_nxt = take_lo ? sum_r : lo_sum_r;
  assign lo_num_nxt = take_lo ? val_r : lo_num_r;

  // Sequencer: load, one digit per cycle, then update and write the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      have_any_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_CMP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            state_r <= ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          if (mag_r == '0) begin
            state_r <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (out_free) begin
            state_r    <= ST_IDLE;
            have_any_r <= !last_r;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers of the digit loop and the sequence extremes.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mag_r  <= in_mag;
      sum_r  <= '0;
      val_r  <= in_value;
      last_r <= in_last;
    end else if (state_r == ST_DIGIT && mag_r != '0) begin
      mag_r <= quot;
      sum_r <= sum_r + dsum_t'(digit);
    end
    if (state_r == ST_CMP && out_free) begin
      hi_sum_r         <= hi_sum_nxt;
      hi_num_r         <= hi_num_nxt;
      lo_sum_r         <= lo_sum_nxt;
      lo_num_r         <= lo_num_nxt;
      out_digit_sum_r  <= sum_r;
      out_max_sum_r    <= hi_sum_nxt;
      out_max_number_r <= hi_num_nxt;
      out_min_sum_r    <= lo_sum_nxt;
      out_min_number_r <= lo_num_nxt;
      out_final_res_r  <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_digit_sum  = out_digit_sum_r;
  assign out_max_sum    = out_max_sum_r;
  assign out_max_number = out_max_number_r;
  assign out_min_sum    = out_min_sum_r;
  assign out_min_number = out_min_number_r;
  assign out_final_res  = out_final_res_r;

  // A result always lies between the running extremes it reports.
  a_result_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_min_sum_r <= out_digit_sum_r) && (out_digit_sum_r <= out_max_sum_r))
    else $error("digit sum outside reported extremes");

  // The digit loop strictly shrinks the magnitude on every step.
  a_loop_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIGIT && mag_r != '0) |=> (mag_r < $past(mag_r)))
    else $error("digit loop did not make progress");

  // The partial digit sum of the magnitude of a signed 32-bit input never exceeds 82.
  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (sum_r <= 7'd82))
    else $error("digit sum out of range");

  // The unit takes no new item right after an input transfer.
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("input accepted while busy");

endmodule

### verif/tb_digit_sum_extremum_tracker.sv
`timescale 1ns / 1ps

module tb_digit_sum_extremum_tracker;
  import dset_pkg::*;

  localparam int unsigned RADIX         = 10;
  localparam int          RESET_CYCLES  = 7;
  localparam int          RANDOM_ITEMS  = 1430;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          QUIET_LIMIT   = 2000;
  localparam int          DRAIN_CYCLES  = 20;
  localparam word_t       MOST_NEGATIVE = 32'sh8000_0000;
  localparam word_t       MOST_POSITIVE = 32'sh7FFF_FFFF;

  // One result as the block reports it.
  typedef struct {
    dsum_t digit_sum;
    dsum_t max_sum;
    word_t max_number;
    dsum_t min_sum;
    word_t min_number;
    logic  final_res;
  } digit_result_t;

  // Running extremes of the current sequence.
  typedef struct {
    bit    seen;
    dsum_t high_sum;
    word_t high_number;
    dsum_t low_sum;
    word_t low_number;
  } extremes_t;

  // A directed row; typed rows are single-item sequences with a known digit sum.
  typedef struct {
    word_t value;
    logic  last;
    bit    typed;
    dsum_t sum;
  } stim_row_t;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  word_t in_value;
  logic  in_last;
  logic  out_valid;
  logic  out_ready;
  dsum_t out_digit_sum;
  dsum_t out_max_sum;
  word_t out_max_number;
  dsum_t out_min_sum;
  word_t out_min_number;
  logic  out_final_res;

  extremes_t     running = '{1'b0, '0, '0, '0, '0};
  digit_result_t pending_results[$];
  stim_row_t     directed_rows[$];
  int unsigned   sender_idle_pct = 0;
  int unsigned   receiver_stall_pct = 0;
  int            holds_requested = 0;
  int            holds_done = 0;
  int            quiet_cycles = 0;
  int            mismatches = 0;
  bit            hand_typed = 1'b0;
  dsum_t         hand_sum = '0;

  digit_sum_extremum_tracker dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_digit_sum (out_digit_sum),
    .out_max_sum   (out_max_sum),
    .out_max_number(out_max_number),
    .out_min_sum   (out_min_sum),
    .out_min_number(out_min_number),
    .out_final_res (out_final_res)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Decimal digit sum of the magnitude; the most negative value keeps its full magnitude.
  function automatic dsum_t digit_total(word_t v);
    mag_t  m;
    dsum_t total;
    m = v[31] ? mag_t'(~v + 32'd1) : mag_t'(v);
    total = '0;
    while (m != 0) begin
      total = total + dsum_t'(m % RADIX);
      m = m / RADIX;
    end
    return total;
  endfunction

  // Fold one number into the running extremes and form its result.
  function automatic digit_result_t track_item(word_t v, logic last);
    digit_result_t r;
    dsum_t         s;
    s = digit_total(v);
    if (!running.seen) begin
      running = '{1'b1, s, v, s, v};
    end else begin
      if (s > running.high_sum) begin
        running.high_sum = s;
        running.high_number = v;
      end
      if (s < running.low_sum) begin
        running.low_sum = s;
        running.low_number = v;
      end
    end
    r = '{s, running.high_sum, running.high_number, running.low_sum, running.low_number, last};
    if (last)
      running = '{1'b0, '0, '0, '0, '0};
    return r;
  endfunction

  // Mix of plain random words, small values, extremes, nine-heavy values and powers of ten.
  function automatic word_t random_value();
    word_t       v;
    int unsigned pow;
    case ($urandom_range(9))
      0: v = word_t'($urandom_range(99));
      1: v = -word_t'($urandom_range(99));
      2: begin
        case ($urandom_range(5))
          0:       v = MOST_NEGATIVE;
          1:       v = MOST_POSITIVE;
          2:       v = '0;
          3:       v = -1;
          4:       v = 1;
          default: v = -MOST_POSITIVE;
        endcase
      end
      3: begin
        v = word_t'(1999999999 - $urandom_range(10000));
        if ($urandom_range(1) == 1)
          v = -v;
      end
      4: begin
        pow = 1;
        repeat ($urandom_range(9)) pow = pow * RADIX;
        v = word_t'(pow);
        if ($urandom_range(1) == 1)
          v = -v;
      end
      default: v = word_t'($urandom);
    endcase
    return v;
  endfunction

  task automatic add_row(word_t v, logic last, bit typed, dsum_t sum);
    directed_rows.push_back('{v, last, typed, sum});
  endtask

  task automatic compare_field(string name, logic signed [32:0] want, logic signed [32:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Offer one item from a falling edge and return at the falling edge after its transfer.
  task automatic send_item(word_t v, logic last, bit typed, dsum_t sum);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= last;
    hand_typed = typed;
    hand_sum = sum;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Result side: random stalls, plus a long hold-off when the sender asks for one.
  initial begin : sink
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done < holds_requested) begin
        holds_done++;
        repeat (HOLD_CYCLES) begin
          out_ready <= 1'b0;
          @(negedge clk);
        end
      end
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Record each input transfer as an expected result and check each result transfer.
  always @(posedge clk) begin : scoreboard
    digit_result_t want;
    digit_result_t got;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
      if (in_valid && in_ready) begin
        want = track_item(in_value, in_last);
        if (hand_typed)
          want = '{hand_sum, hand_sum, in_value, hand_sum, in_value, 1'b1};
        pending_results.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = '{out_digit_sum, out_max_sum, out_max_number, out_min_sum, out_min_number,
                out_final_res};
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected: digit_sum %0d", out_digit_sum);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          compare_field("digit_sum", want.digit_sum, got.digit_sum);
          compare_field("max_sum", want.max_sum, got.max_sum);
          compare_field("max_number", want.max_number, got.max_number);
          compare_field("min_sum", want.min_sum, got.min_sum);
          compare_field("min_number", want.min_number, got.min_number);
          compare_field("final_res", want.final_res, got.final_res);
        end
      end
    end
  end

  // Ends the run if nothing moves on either channel for too long.
  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("digit_sum_extremum_tracker: mismatch");
    $finish;
  end

  initial begin : stimulus
    int sent;
    int phase;
    int seq_len;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    in_last = 1'b0;

    // Single-item sequences with digit sums read off by hand.
    add_row(0, 1'b1, 1'b1, 0);
    add_row(MOST_NEGATIVE, 1'b1, 1'b1, 47);
    add_row(MOST_POSITIVE, 1'b1, 1'b1, 46);
    add_row(-1, 1'b1, 1'b1, 1);
    add_row(1999999999, 1'b1, 1'b1, 82);
    add_row(-1999999999, 1'b1, 1'b1, 82);
    // A longer sequence with ties on both extremes, zero and the largest digit sum.
    add_row(5, 1'b0, 1'b0, 0);
    add_row(14, 1'b0, 1'b0, 0);
    add_row(99, 1'b0, 1'b0, 0);
    add_row(-99, 1'b0, 1'b0, 0);
    add_row(0, 1'b0, 1'b0, 0);
    add_row(-1999999999, 1'b0, 1'b0, 0);
    add_row(10, 1'b1, 1'b0, 0);
    // The two extreme values inside one sequence.
    add_row(MOST_NEGATIVE, 1'b0, 1'b0, 0);
    add_row(MOST_POSITIVE, 1'b0, 1'b0, 0);
    add_row(MOST_NEGATIVE, 1'b0, 1'b0, 0);
    add_row(1000000000, 1'b1, 1'b0, 0);
    add_row(7, 1'b0, 1'b0, 0);
    add_row(7, 1'b1, 1'b0, 0);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].value, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].sum);

    // Random sequences, spread over four idling phases.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase = sent * 4 / RANDOM_ITEMS;
      case (phase)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 84;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 84;
        end
        default: begin
          sender_idle_pct = 27;
          receiver_stall_pct = 27;
        end
      endcase
      seq_len = ($urandom_range(19) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
      for (int k = 0; k < seq_len; k++) begin
        if (sent == RANDOM_ITEMS / 8)
          holds_requested++;
        send_item(random_value(), k == seq_len - 1, 1'b0, '0);
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("digit_sum_extremum_tracker: match");
    else
      $display("digit_sum_extremum_tracker: mismatch");
    $finish;
  end

endmodule
